// ===== hw/rtl/aat_pkg.sv =====
// Shared types, sizes and codes for the active alarm table.
// No dependencies; every other file of the block but aat_ram refers to this package by scoped names.
package aat_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int LOG_DEPTH   = 32;

    localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LOG_AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int FILL_W = $clog2(LOG_DEPTH + 1);

    // request codes
    localparam logic [2:0] ACT_RAISE     = 3'd0;
    localparam logic [2:0] ACT_ACK       = 3'd1;
    localparam logic [2:0] ACT_CLEAR     = 3'd2;
    localparam logic [2:0] ACT_CLEAR_ALL = 3'd3;
    localparam logic [2:0] ACT_QUERY     = 3'd4;
    localparam logic [2:0] ACT_HIST      = 3'd5;

    // result codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ACTIVE     = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_HIST_EMPTY = 3'd4;

    // history event codes
    localparam logic [1:0] EV_RAISED  = 2'd0;
    localparam logic [1:0] EV_ACKED   = 2'd1;
    localparam logic [1:0] EV_CLEARED = 2'd2;

    localparam logic [1:0] SEV_CRIT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_CLRALL,
        S_LEDS,
        S_HIST,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] raise_time;
        logic        acked;
        logic [1:0]  severity;
        logic [15:0] id;
    } entry_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [1:0]  event_code;
        logic [1:0]  severity;
        logic [15:0] id;
    } log_t;

    typedef struct packed {
        logic [4:0]  history_slot;
        logic [31:0] now_seconds;
        logic [1:0]  severity;
        logic [15:0] alm_id;
        logic [2:0]  action;
    } req_t;

    // first member sits in the highest bits
    typedef struct packed {
        logic [5:0]  log_used;
        logic [31:0] hist_time;
        logic [1:0]  hist_event;
        logic [1:0]  hist_severity;
        logic [15:0] hist_id;
        logic        status_led;
        logic        alarm_led;
        logic [4:0]  crit_active;
        logic [4:0]  active_count;
        logic [31:0] duration;
        logic        is_acknowledged;
        logic [2:0]  status;
    } res_t;

endpackage

// ===== hw/rtl/aat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/aat_unit.sv =====
// Shared compare and subtract unit applied to one table entry per cycle.
// Depends on aat_pkg for the entry layout.
module aat_unit (
    input  logic [15:0]     req_id,
    input  logic [31:0]     now_seconds,
    input  aat_pkg::entry_t ent,
    output logic            match,
    output logic            crit,
    output logic [31:0]     duration
);

    assign match    = (ent.id == req_id);
    assign crit     = (ent.severity >= aat_pkg::SEV_CRIT);
    // wraps modulo 2^32
    assign duration = now_seconds - ent.raise_time;

endmodule

// ===== hw/rtl/aat_core.sv =====
// Sequencer, counters and LED state of the alarm table, with the table and history RAMs.
// Depends on aat_pkg, aat_ram and aat_unit.
module aat_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  aat_pkg::req_t req_in,
    output logic          ready,
    input  logic          out_free,
    output logic          res_valid,
    output aat_pkg::res_t res
);

    localparam int CW  = aat_pkg::CNT_W;
    localparam int FW  = aat_pkg::FILL_W;
    localparam int TAW = aat_pkg::TBL_AW;
    localparam int LAW = aat_pkg::LOG_AW;

    aat_pkg::state_t state_reg, state_next;
    aat_pkg::req_t   req_reg, req_next;
    aat_pkg::res_t   res_reg, res_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   crit_reg, crit_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [LAW-1:0]  next_reg, next_next;
    logic            alarm_led_reg, alarm_led_next;
    logic            status_led_reg, status_led_next;

    logic [CW:0]     scan_inc;
    logic            tbl_we;
    logic [TAW-1:0]  tbl_waddr, tbl_raddr;
    aat_pkg::entry_t tbl_wdata, ent;
    logic [$bits(aat_pkg::entry_t)-1:0] tbl_rdata;
    logic            log_add, log_we;
    logic [LAW-1:0]  log_waddr, log_raddr;
    aat_pkg::log_t   log_item, log_ent;
    logic [$bits(aat_pkg::log_t)-1:0] log_rdata;
    logic            ent_match, ent_crit;
    logic [31:0]     ent_dur;
    logic            at_end, hist_ok;

    aat_ram #(
        .WIDTH ($bits(aat_pkg::entry_t)),
        .DEPTH (aat_pkg::TABLE_DEPTH)
    ) u_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    aat_ram #(
        .WIDTH ($bits(aat_pkg::log_t)),
        .DEPTH (aat_pkg::LOG_DEPTH)
    ) u_log (
        .aclk  (aclk),
        .we    (log_we),
        .waddr (log_waddr),
        .wdata (log_item),
        .raddr (log_raddr),
        .rdata (log_rdata)
    );

    assign ent     = aat_pkg::entry_t'(tbl_rdata);
    assign log_ent = aat_pkg::log_t'(log_rdata);

    aat_unit u_unit (
        .req_id      (req_reg.alm_id),
        .now_seconds (req_reg.now_seconds),
        .ent         (ent),
        .match       (ent_match),
        .crit        (ent_crit),
        .duration    (ent_dur)
    );

    assign scan_inc = {1'b0, scan_reg} + {{CW{1'b0}}, 1'b1};
    assign at_end   = (scan_reg == count_reg);
    assign hist_ok  = ({3'b0, req_reg.history_slot} < 8'(fill_reg))
                   && (int'(req_reg.history_slot) < aat_pkg::LOG_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= aat_pkg::S_IDLE;
            count_reg      <= '0;
            crit_reg       <= '0;
            fill_reg       <= '0;
            next_reg       <= '0;
            alarm_led_reg  <= 1'b0;
            status_led_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            crit_reg       <= crit_next;
            fill_reg       <= fill_next;
            next_reg       <= next_next;
            alarm_led_reg  <= alarm_led_next;
            status_led_reg <= status_led_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        res_reg  <= res_next;
        scan_reg <= scan_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            aat_pkg::S_IDLE: begin
                if (start) begin
                    unique case (req_in.action)
                        aat_pkg::ACT_RAISE,
                        aat_pkg::ACT_ACK,
                        aat_pkg::ACT_CLEAR,
                        aat_pkg::ACT_QUERY:     state_next = aat_pkg::S_SEARCH;
                        aat_pkg::ACT_CLEAR_ALL: state_next = aat_pkg::S_CLRALL;
                        aat_pkg::ACT_HIST:      state_next = aat_pkg::S_HIST;
                        default:                state_next = aat_pkg::S_FINISH;
                    endcase
                end
            end
            aat_pkg::S_SEARCH: begin
                if (at_end) begin
                    if (req_reg.action == aat_pkg::ACT_RAISE &&
                        count_reg < CW'(aat_pkg::TABLE_DEPTH)) begin
                        state_next = aat_pkg::S_LEDS;
                    end else begin
                        state_next = aat_pkg::S_FINISH;
                    end
                end else if (ent_match) begin
                    unique case (req_reg.action)
                        aat_pkg::ACT_ACK:   state_next = aat_pkg::S_LEDS;
                        aat_pkg::ACT_CLEAR: state_next = aat_pkg::S_SHIFT;
                        default:            state_next = aat_pkg::S_FINISH;
                    endcase
                end
            end
            aat_pkg::S_SHIFT: begin
                if (scan_inc >= {1'b0, count_reg}) begin
                    state_next = aat_pkg::S_LEDS;
                end
            end
            aat_pkg::S_CLRALL: begin
                if (at_end) begin
                    state_next = aat_pkg::S_LEDS;
                end
            end
            aat_pkg::S_LEDS:   state_next = aat_pkg::S_FINISH;
            aat_pkg::S_HIST:   state_next = aat_pkg::S_FINISH;
            aat_pkg::S_FINISH: begin
                if (out_free) begin
                    state_next = aat_pkg::S_IDLE;
                end
            end
            default: state_next = aat_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        req_next        = req_reg;
        res_next        = res_reg;
        count_next      = count_reg;
        crit_next       = crit_reg;
        scan_next       = scan_reg;
        fill_next       = fill_reg;
        next_next       = next_reg;
        alarm_led_next  = alarm_led_reg;
        status_led_next = status_led_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = TAW'(scan_reg);
        tbl_wdata       = ent;
        tbl_raddr       = '0;
        log_add         = 1'b0;
        log_we          = 1'b0;
        log_waddr       = next_reg;
        log_item        = '0;
        log_raddr       = LAW'(req_in.history_slot);

        unique case (state_reg)
            aat_pkg::S_IDLE: begin
                // table read of slot 0 and the history read are issued here
                if (start) begin
                    req_next  = req_in;
                    res_next  = '0;
                    scan_next = '0;
                end
            end
            aat_pkg::S_SEARCH: begin
                tbl_raddr = TAW'(scan_inc);
                if (at_end) begin
                    if (req_reg.action == aat_pkg::ACT_RAISE) begin
                        if (count_reg >= CW'(aat_pkg::TABLE_DEPTH)) begin
                            res_next.status = aat_pkg::ST_FULL;
                        end else begin
                            tbl_we                 = 1'b1;
                            tbl_waddr              = TAW'(count_reg);
                            tbl_wdata.id           = req_reg.alm_id;
                            tbl_wdata.severity     = req_reg.severity;
                            tbl_wdata.acked        = 1'b0;
                            tbl_wdata.raise_time   = req_reg.now_seconds;
                            count_next             = count_reg + CW'(1);
                            if (req_reg.severity >= aat_pkg::SEV_CRIT) begin
                                crit_next = crit_reg + CW'(1);
                            end
                            log_add             = 1'b1;
                            log_item.id         = req_reg.alm_id;
                            log_item.severity   = req_reg.severity;
                            log_item.event_code = aat_pkg::EV_RAISED;
                            log_item.stamp      = req_reg.now_seconds;
                        end
                    end else begin
                        res_next.status = aat_pkg::ST_NOT_FOUND;
                    end
                end else if (ent_match) begin
                    log_item.id       = req_reg.alm_id;
                    log_item.severity = ent.severity;
                    log_item.stamp    = req_reg.now_seconds;
                    unique case (req_reg.action)
                        aat_pkg::ACT_RAISE: res_next.status = aat_pkg::ST_ACTIVE;
                        aat_pkg::ACT_ACK: begin
                            tbl_we              = 1'b1;
                            tbl_wdata.acked     = 1'b1;
                            log_add             = 1'b1;
                            log_item.event_code = aat_pkg::EV_ACKED;
                        end
                        aat_pkg::ACT_CLEAR: begin
                            // read of the following entry is already in flight
                            log_add             = 1'b1;
                            log_item.event_code = aat_pkg::EV_CLEARED;
                            if (ent_crit) begin
                                crit_next = crit_reg - CW'(1);
                            end
                        end
                        default: begin
                            res_next.is_acknowledged = ent.acked;
                            res_next.duration        = ent_dur;
                        end
                    endcase
                end else begin
                    scan_next = CW'(scan_inc);
                end
            end
            aat_pkg::S_SHIFT: begin
                // move entry scan+1 (in the read register) down to scan
                if (scan_inc < {1'b0, count_reg}) begin
                    tbl_we    = 1'b1;
                    tbl_raddr = TAW'(scan_inc + {{CW{1'b0}}, 1'b1});
                    scan_next = CW'(scan_inc);
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            aat_pkg::S_CLRALL: begin
                tbl_raddr = TAW'(scan_inc);
                if (!at_end) begin
                    log_add             = 1'b1;
                    log_item.id         = ent.id;
                    log_item.severity   = ent.severity;
                    log_item.event_code = aat_pkg::EV_CLEARED;
                    log_item.stamp      = req_reg.now_seconds;
                    scan_next           = CW'(scan_inc);
                end else begin
                    count_next = '0;
                    crit_next  = '0;
                end
            end
            aat_pkg::S_LEDS: begin
                if (crit_reg != '0) begin
                    alarm_led_next = ~alarm_led_reg;
                end else begin
                    alarm_led_next = (count_reg != '0);
                end
                if (count_reg == '0) begin
                    status_led_next = 1'b1;
                end else begin
                    status_led_next = ~status_led_reg;
                end
            end
            aat_pkg::S_HIST: begin
                if (hist_ok) begin
                    res_next.hist_id       = log_ent.id;
                    res_next.hist_severity = log_ent.severity;
                    res_next.hist_event    = log_ent.event_code;
                    res_next.hist_time     = log_ent.stamp;
                end else begin
                    res_next.status = aat_pkg::ST_HIST_EMPTY;
                end
            end
            default: begin
            end
        endcase

        // append to the ring: fill in order, then overwrite oldest first
        if (log_add) begin
            log_we = 1'b1;
            if (fill_reg < FW'(aat_pkg::LOG_DEPTH)) begin
                log_waddr = LAW'(fill_reg);
                fill_next = fill_reg + FW'(1);
            end else begin
                log_waddr = next_reg;
                if (next_reg == LAW'(aat_pkg::LOG_DEPTH - 1)) begin
                    next_next = '0;
                end else begin
                    next_next = next_reg + LAW'(1);
                end
            end
        end
    end

    // outputs
    always_comb begin
        ready              = (state_reg == aat_pkg::S_IDLE);
        res_valid          = (state_reg == aat_pkg::S_FINISH);
        res                = res_reg;
        res.active_count   = 5'(count_reg);
        res.crit_active    = 5'(crit_reg);
        res.alarm_led      = alarm_led_reg;
        res.status_led     = status_led_reg;
        res.log_used       = 6'(fill_reg);
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(aat_pkg::TABLE_DEPTH))
        else $error("active count beyond table depth");

    a_crit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        crit_reg <= count_reg)
        else $error("critical count above active count");

    a_ring_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_reg != '0) |-> (fill_reg == FW'(aat_pkg::LOG_DEPTH)))
        else $error("ring overwrite pointer moved before ring filled");

    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (state_reg != aat_pkg::S_IDLE))
        else $error("sequencer idle right after taking an item");

endmodule

// ===== hw/rtl/active_alarm_table.sv =====
// Active alarm table top level: stream ports, item unpacking and the result register.
// Depends on aat_pkg and aat_core.
// Sequencing: an unused code goes from S_IDLE straight to S_FINISH, a history read passes S_HIST,
//   and raise, acknowledge, clear, query or clear-all step through the table; the table RAM
//   read port is stepped one entry per cycle by the search, shift and clear-all loops.
// Throughput: one item at a time; s_tready rises with m_tvalid, so a new item is taken only
//   after the result of the last one has moved into the output register.
// Reset: aresetn synchronous, active low; clears counts, history fill and LEDs. The RAMs are
//   not swept: entries beyond the counts are never used.
module active_alarm_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // alm_id[15:0], severity[17:16], now_seconds[49:18], history_slot[54:50], zero pad
    input  logic [55:0]  s_tdata,
    // action[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], is_acknowledged[3], duration[35:4], active_count[40:36],
    // crit_active[45:41], alarm_led[46], status_led[47], hist_id[63:48],
    // hist_severity[65:64], hist_event[67:66], hist_time[99:68], log_used[105:100], pad
    output logic [111:0] m_tdata
);

    aat_pkg::req_t req;
    aat_pkg::res_t core_res;
    aat_pkg::res_t res_reg, res_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          core_ready, core_done, out_free, start;

    assign req.action       = s_tuser;
    assign req.alm_id       = s_tdata[15:0];
    assign req.severity     = s_tdata[17:16];
    assign req.now_seconds  = s_tdata[49:18];
    assign req.history_slot = s_tdata[54:50];

    assign start    = s_tvalid && core_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    aat_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req_in    (req),
        .ready     (core_ready),
        .out_free  (out_free),
        .res_valid (core_done),
        .res       (core_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        res_next      = res_reg;
        if (core_done && out_free) begin
            m_tvalid_next = 1'b1;
            res_next      = core_res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        res_reg <= res_next;
    end

    assign s_tready = core_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, res_reg};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for active_alarm_table: drives request items, predicts every result
// from its own copy of the table, history ring and LEDs. Depends on aat_pkg and the RTL.
module testbench;

    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;
    localparam logic [1:0] SEV_INFO    = 2'd0;
    localparam logic [1:0] SEV_WARN    = 2'd1;
    localparam logic [1:0] SEV_EMERG   = 2'd3;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = aat_pkg::TABLE_DEPTH + 10;
    localparam int POOL_SIZE    = 20;
    localparam int PRINT_LIMIT  = 40;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;

    active_alarm_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // shadow copy of the alarm table
    logic [15:0] active_ids   [aat_pkg::TABLE_DEPTH];
    logic [1:0]  active_sevs  [aat_pkg::TABLE_DEPTH];
    logic        active_acked [aat_pkg::TABLE_DEPTH];
    logic [31:0] active_since [aat_pkg::TABLE_DEPTH];
    int          tbl_count;

    // shadow copy of the history ring
    logic [15:0] ring_ids   [aat_pkg::LOG_DEPTH];
    logic [1:0]  ring_sevs  [aat_pkg::LOG_DEPTH];
    logic [1:0]  ring_codes [aat_pkg::LOG_DEPTH];
    logic [31:0] ring_stamp [aat_pkg::LOG_DEPTH];
    int          ring_fill;
    int          ring_next;

    logic alarm_lvl;
    logic status_lvl;

    aat_pkg::res_t request_outcomes[$];

    int          mismatch_count;
    int          requests_sent;
    int          results_seen;
    int          full_refusals;
    int          ring_overwrites;
    int          tx_gap_max;
    int          rx_stall_pct;
    int          burst_left;
    bit          hold_request;
    logic [31:0] clock_now;
    logic [15:0] id_pool [POOL_SIZE];

    function automatic int find_alarm(logic [15:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (active_ids[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int count_critical();
        int n;
        n = 0;
        for (int i = 0; i < tbl_count; i++)
            if (active_sevs[i] >= aat_pkg::SEV_CRIT)
                n++;
        return n;
    endfunction

    function automatic void record_history(logic [15:0] id, logic [1:0] sev, logic [1:0] code,
                                           logic [31:0] stamp);
        int s;
        if (ring_fill < aat_pkg::LOG_DEPTH) begin
            s = ring_fill;
            ring_fill++;
        end else begin
            s = ring_next;
            ring_next = (s + 1) % aat_pkg::LOG_DEPTH;
            ring_overwrites++;
        end
        ring_ids[s]   = id;
        ring_sevs[s]  = sev;
        ring_codes[s] = code;
        ring_stamp[s] = stamp;
    endfunction

    function automatic void update_leds();
        if (count_critical() > 0)
            alarm_lvl = ~alarm_lvl;
        else
            alarm_lvl = (tbl_count > 0);
        status_lvl = (tbl_count == 0) ? 1'b1 : ~status_lvl;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < aat_pkg::TABLE_DEPTH; i++) begin
            active_ids[i]   = '0;
            active_sevs[i]  = '0;
            active_acked[i] = 1'b0;
            active_since[i] = '0;
        end
        for (int i = 0; i < aat_pkg::LOG_DEPTH; i++) begin
            ring_ids[i]   = '0;
            ring_sevs[i]  = '0;
            ring_codes[i] = '0;
            ring_stamp[i] = '0;
        end
        tbl_count  = 0;
        ring_fill  = 0;
        ring_next  = 0;
        alarm_lvl  = 1'b0;
        status_lvl = 1'b0;
    endfunction

    // advance the shadow state by one request and return the result it produces
    function automatic aat_pkg::res_t apply_request(logic [2:0] act, logic [15:0] id,
                                                    logic [1:0] sev, logic [31:0] now,
                                                    logic [4:0] slot);
        aat_pkg::res_t r;
        int            k;
        r = '0;
        k = find_alarm(id);
        case (act)
            aat_pkg::ACT_RAISE: begin
                if (k >= 0) begin
                    r.status = aat_pkg::ST_ACTIVE;
                end else if (tbl_count >= aat_pkg::TABLE_DEPTH) begin
                    r.status = aat_pkg::ST_FULL;
                    full_refusals++;
                end else begin
                    active_ids[tbl_count]   = id;
                    active_sevs[tbl_count]  = sev;
                    active_acked[tbl_count] = 1'b0;
                    active_since[tbl_count] = now;
                    tbl_count++;
                    record_history(id, sev, aat_pkg::EV_RAISED, now);
                    update_leds();
                end
            end
            aat_pkg::ACT_ACK: begin
                if (k < 0) begin
                    r.status = aat_pkg::ST_NOT_FOUND;
                end else begin
                    active_acked[k] = 1'b1;
                    record_history(id, active_sevs[k], aat_pkg::EV_ACKED, now);
                    update_leds();
                end
            end
            aat_pkg::ACT_CLEAR: begin
                if (k < 0) begin
                    r.status = aat_pkg::ST_NOT_FOUND;
                end else begin
                    record_history(id, active_sevs[k], aat_pkg::EV_CLEARED, now);
                    // close the gap left by the removed entry
                    for (int i = k; i + 1 < tbl_count; i++) begin
                        active_ids[i]   = active_ids[i + 1];
                        active_sevs[i]  = active_sevs[i + 1];
                        active_acked[i] = active_acked[i + 1];
                        active_since[i] = active_since[i + 1];
                    end
                    tbl_count--;
                    update_leds();
                end
            end
            aat_pkg::ACT_CLEAR_ALL: begin
                for (int i = 0; i < tbl_count; i++)
                    record_history(active_ids[i], active_sevs[i], aat_pkg::EV_CLEARED, now);
                tbl_count = 0;
                update_leds();
            end
            aat_pkg::ACT_QUERY: begin
                if (k < 0) begin
                    r.status = aat_pkg::ST_NOT_FOUND;
                end else begin
                    r.is_acknowledged = active_acked[k];
                    r.duration        = now - active_since[k];
                end
            end
            aat_pkg::ACT_HIST: begin
                if (int'(slot) >= ring_fill) begin
                    r.status = aat_pkg::ST_HIST_EMPTY;
                end else begin
                    r.hist_id       = ring_ids[slot];
                    r.hist_severity = ring_sevs[slot];
                    r.hist_event    = ring_codes[slot];
                    r.hist_time     = ring_stamp[slot];
                end
            end
            default: ;
        endcase
        r.active_count = 5'(tbl_count);
        r.crit_active  = 5'(count_critical());
        r.alarm_led    = alarm_lvl;
        r.status_led   = status_lvl;
        r.log_used     = 6'(ring_fill);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("ERROR result %0d: %s got %0h, expected %0h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    // offer one item, hold it until accepted, then predict its result
    task automatic send_req(logic [2:0] act, logic [15:0] id, logic [1:0] sev,
                            logic [31:0] now, logic [4:0] slot);
        int gap;
        if (burst_left == 0) begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, slot, now, sev, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        requests_sent++;
        request_outcomes.push_back(apply_request(act, id, sev, now, slot));
    endtask

    function automatic logic [31:0] next_stamp();
        if ($urandom_range(0, 19) == 0)
            clock_now = $urandom;
        else
            clock_now = clock_now + $urandom_range(0, 5000);
        return clock_now;
    endfunction

    function automatic logic [15:0] pick_id(bit prefer_present);
        if (prefer_present && tbl_count > 0 && $urandom_range(0, 9) < 7)
            return active_ids[$urandom_range(0, tbl_count - 1)];
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [4:0] pick_slot();
        if (ring_fill > 0 && $urandom_range(0, 3) != 0)
            return 5'($urandom_range(0, ring_fill - 1));
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic test_empty_table();
        send_req(aat_pkg::ACT_HIST, 16'h0000, SEV_INFO, 32'd0, 5'd0);
        send_req(aat_pkg::ACT_QUERY, 16'h0000, SEV_INFO, 32'd10, 5'd0);
        send_req(aat_pkg::ACT_ACK, 16'hFFFF, SEV_EMERG, 32'hFFFF_FFFF, 5'h1F);
        send_req(aat_pkg::ACT_CLEAR, 16'h1234, SEV_WARN, 32'd20, 5'd3);
        send_req(aat_pkg::ACT_CLEAR_ALL, 16'h0000, SEV_INFO, 32'd30, 5'd0);
        send_req(ACT_SPARE_A, 16'hFFFF, SEV_EMERG, 32'hFFFF_FFFF, 5'h1F);
        send_req(ACT_SPARE_B, 16'hA5A5, aat_pkg::SEV_CRIT, 32'h5A5A_5A5A, 5'h15);
    endtask

    task automatic test_single_alarms();
        send_req(aat_pkg::ACT_RAISE, 16'h0000, SEV_INFO, 32'd0, 5'd0);
        send_req(aat_pkg::ACT_RAISE, 16'hFFFF, SEV_EMERG, 32'hFFFF_FFFF, 5'h1F);
        send_req(aat_pkg::ACT_RAISE, 16'h0000, SEV_WARN, 32'd5, 5'd0);
        send_req(aat_pkg::ACT_RAISE, 16'h00A5, aat_pkg::SEV_CRIT, 32'd100, 5'd0);
        send_req(aat_pkg::ACT_ACK, 16'hFFFF, SEV_INFO, 32'd1, 5'd0);
        send_req(aat_pkg::ACT_ACK, 16'hFFFF, SEV_INFO, 32'd2, 5'd0);
        // raise time sits just below the wrap, so the age wraps too
        send_req(aat_pkg::ACT_QUERY, 16'hFFFF, SEV_INFO, 32'd3, 5'd0);
        send_req(aat_pkg::ACT_QUERY, 16'h0000, SEV_INFO, 32'd50, 5'd0);
        send_req(aat_pkg::ACT_CLEAR, 16'h0000, SEV_INFO, 32'd60, 5'd0);
        send_req(aat_pkg::ACT_HIST, 16'h0000, SEV_INFO, 32'd61, 5'd0);
        send_req(aat_pkg::ACT_HIST, 16'h0000, SEV_INFO, 32'd62, 5'd5);
        send_req(aat_pkg::ACT_HIST, 16'h0000, SEV_INFO, 32'd63, 5'h1F);
        send_req(aat_pkg::ACT_CLEAR_ALL, 16'h0000, SEV_INFO, 32'd70, 5'd0);
    endtask

    task automatic test_table_full();
        tx_gap_max   = 3;
        rx_stall_pct = 20;
        send_req(aat_pkg::ACT_CLEAR_ALL, pick_id(0), 2'($urandom), next_stamp(), pick_slot());
        while (tbl_count < aat_pkg::TABLE_DEPTH)
            send_req(aat_pkg::ACT_RAISE, 16'($urandom), 2'($urandom), next_stamp(),
                     pick_slot());
        send_req(aat_pkg::ACT_RAISE, pick_id(0), 2'($urandom), next_stamp(), pick_slot());
        send_req(aat_pkg::ACT_RAISE, active_ids[aat_pkg::TABLE_DEPTH - 1], SEV_INFO,
                 next_stamp(), pick_slot());
        send_req(aat_pkg::ACT_CLEAR, active_ids[$urandom_range(1, aat_pkg::TABLE_DEPTH - 2)],
                 SEV_INFO, next_stamp(), pick_slot());
        send_req(aat_pkg::ACT_ACK, active_ids[0], SEV_INFO, next_stamp(), pick_slot());
        send_req(aat_pkg::ACT_QUERY, active_ids[tbl_count - 1], SEV_INFO, next_stamp(),
                 pick_slot());
        send_req(aat_pkg::ACT_QUERY, active_ids[0], SEV_INFO, next_stamp(), pick_slot());
        send_req(aat_pkg::ACT_CLEAR_ALL, pick_id(0), SEV_INFO, next_stamp(), pick_slot());
    endtask

    task automatic test_random_traffic(int n_items, int gap_max, int stall_pct,
                                       bit with_clear_all);
        int          pick;
        logic [2:0]  act;
        tx_gap_max   = gap_max;
        rx_stall_pct = stall_pct;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                act = aat_pkg::ACT_RAISE;
            else if (pick < 50)
                act = aat_pkg::ACT_ACK;
            else if (pick < 64)
                act = aat_pkg::ACT_CLEAR;
            else if (pick < 78)
                act = aat_pkg::ACT_QUERY;
            else if (pick < 92)
                act = aat_pkg::ACT_HIST;
            else if (pick < 96)
                act = with_clear_all ? aat_pkg::ACT_CLEAR_ALL : aat_pkg::ACT_QUERY;
            else
                act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
            send_req(act, pick_id(act != aat_pkg::ACT_RAISE), 2'($urandom), next_stamp(),
                     pick_slot());
        end
    endtask

    // stop draining results for a long stretch while items keep coming
    task automatic test_backpressure();
        tx_gap_max   = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        repeat (12)
            send_req($urandom_range(0, 1) ? aat_pkg::ACT_RAISE : aat_pkg::ACT_QUERY,
                     pick_id(1), 2'($urandom), next_stamp(), pick_slot());
    endtask

    // result receiver with random stalls and an optional long hold-off
    initial begin : rx_side
        int held;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        aat_pkg::res_t got;
        aat_pkg::res_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
            got = m_tdata[$bits(aat_pkg::res_t)-1:0];
            results_seen++;
            if (request_outcomes.size() == 0) begin
                report_mismatch("result with nothing pending, status", got.status, 0);
            end else begin
                want = request_outcomes.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.is_acknowledged !== want.is_acknowledged)
                    report_mismatch("is_acknowledged", got.is_acknowledged,
                                    want.is_acknowledged);
                if (got.duration !== want.duration)
                    report_mismatch("duration", got.duration, want.duration);
                if (got.active_count !== want.active_count)
                    report_mismatch("active_count", got.active_count, want.active_count);
                if (got.crit_active !== want.crit_active)
                    report_mismatch("crit_active", got.crit_active, want.crit_active);
                if (got.alarm_led !== want.alarm_led)
                    report_mismatch("alarm_led", got.alarm_led, want.alarm_led);
                if (got.status_led !== want.status_led)
                    report_mismatch("status_led", got.status_led, want.status_led);
                if (got.hist_id !== want.hist_id)
                    report_mismatch("hist_id", got.hist_id, want.hist_id);
                if (got.hist_severity !== want.hist_severity)
                    report_mismatch("hist_severity", got.hist_severity, want.hist_severity);
                if (got.hist_event !== want.hist_event)
                    report_mismatch("hist_event", got.hist_event, want.hist_event);
                if (got.hist_time !== want.hist_time)
                    report_mismatch("hist_time", got.hist_time, want.hist_time);
                if (got.log_used !== want.log_used)
                    report_mismatch("log_used", got.log_used, want.log_used);
            end
        end
    end

    initial begin : watchdog
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge aclk);
        $display("ERROR run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        mismatch_count  = 0;
        requests_sent   = 0;
        results_seen    = 0;
        full_refusals   = 0;
        ring_overwrites = 0;
        burst_left      = 0;
        hold_request    = 1'b0;
        tx_gap_max      = 4;
        rx_stall_pct    = 30;
        clock_now       = $urandom;
        id_pool[0]      = 16'h0000;
        id_pool[1]      = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = 16'($urandom);
        clear_shadow();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_single_alarms();
        test_table_full();
        test_random_traffic(80, 4, 30, 1'b1);
        test_random_traffic(80, 0, 0, 1'b1);
        test_backpressure();
        test_random_traffic(80, 10, 60, 1'b0);
        test_table_full();
        test_random_traffic(80, 2, 10, 1'b1);
        s_tvalid <= 1'b0;

        while (request_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests and checked %0d results across idle, stall and hold-off",
                 requests_sent, results_seen);
        $display("Table-full refusals: %0d, history slots overwritten: %0d",
                 full_refusals, ring_overwrites);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
